### src/rcca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcca_pkg
// Shared types, constants and helpers of the restricted-radix converter.
// ----------------------------------------------------------------------------
package rcca_pkg;

  localparam int MAX_SYMBOLS = 36;
  localparam int VALUE_BITS  = 63;

  localparam int SYM_W  = $clog2(MAX_SYMBOLS + 1);   // symbol index, base, digit
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);    // digit count
  localparam int DIG_AW = $clog2(VALUE_BITS);        // digit store address
  localparam int ITER_W = $clog2(VALUE_BITS);        // divider step counter
  localparam int CHAR_W = 7;
  localparam int CFG_W  = MAX_SYMBOLS;

  localparam logic [5:0]        SYMBOL_COUNT_RESET = 6'd10;
  localparam logic [CHAR_W-1:0] ASCII_ZERO         = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A      = 7'h41;
  localparam logic [CHAR_W-1:0] DEC_DIGITS         = 7'd10;

  typedef enum logic {
    CFG_SYMBOL_COUNT = 1'b0,
    CFG_BANNED_MASK  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FETCH,
    ST_MAP,
    ST_EMIT
  } state_e;

  // Divider start control, driven by the sequencer.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  function automatic logic [CHAR_W-1:0] glyph_of(input logic [SYM_W-1:0] idx);
    logic [CHAR_W-1:0] wide;
    wide = CHAR_W'(idx);
    if (wide < DEC_DIGITS) begin
      return ASCII_ZERO + wide;
    end
    return ASCII_UPPER_A + wide - DEC_DIGITS;
  endfunction

endpackage

### src/rcca_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcca_divider
// Restoring radix-2 divider: one quotient bit per cycle, VALUE_BITS steps.
// ----------------------------------------------------------------------------
module rcca_divider
  import rcca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  div_ctrl_t             ctrl_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [SYM_W-1:0]      divisor_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quot_o,
  output logic [SYM_W-1:0]      rem_o
);

  logic                  busy_q;
  logic                  done_q;
  logic [ITER_W-1:0]     iter_q;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [SYM_W-1:0]      rem_q, rem_d;
  logic [SYM_W:0]        rem_sh;
  logic                  ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[VALUE_BITS-1]};
    ge     = (rem_sh >= {1'b0, divisor_i});
    rem_d  = ge ? SYM_W'(rem_sh - {1'b0, divisor_i}) : SYM_W'(rem_sh);
    quo_d  = {quo_q[VALUE_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        iter_q <= ITER_W'(VALUE_BITS - 1);
      end else if (busy_q) begin
        iter_q <= iter_q - 1'b1;
        if (iter_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

### src/radix_convert_custom_alphabet_core.sv
// Sequence: a scan over the candidate symbols, then one serial division per
// digit in the divider, then per digit one store read, a symbol lookup over up
// to count candidates and the output of the symbol.
// Throughput: one value at a time; the input is ready only when idle.
// The divider's one-bit-per-cycle loop takes the bulk of the conversion time.
// Reset: symbol_count returns to 10, banned_mask to 0, the sequencer idles.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_convert_custom_alphabet_core
// Writes a value in the radix set by the allowed symbols, MSB digit first.
// ----------------------------------------------------------------------------
module radix_convert_custom_alphabet_core
  import rcca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CHAR_W-1:0]     symbol_char_o,
  output logic                  is_last_o,
  output logic                  is_empty_o,
  output logic                  bad_base_o
);

  logic [5:0]       sym_count_q;
  logic [CFG_W-1:0] banned_q;

  state_e state_q, state_d;

  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [SYM_W-1:0]      base_q, base_d;
  logic [SYM_W-1:0]      idx_q, idx_d;       // scan / lookup position
  logic [SYM_W-1:0]      seen_q, seen_d;     // allowed symbols passed in lookup
  logic [CNT_W-1:0]      ndig_q, ndig_d;
  logic [DIG_AW-1:0]     rd_idx_q, rd_idx_d;
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     sym_q, sym_d;
  logic                  last_q, last_d;
  logic                  empty_q, empty_d;
  logic                  bad_q, bad_d;

  logic [SYM_W-1:0]      cnt_eff;
  logic                  cur_allowed;

  logic [SYM_W-1:0]      dig_mem [VALUE_BITS];
  logic [SYM_W-1:0]      dig_rd_q;
  logic                  mem_we;

  div_ctrl_t             div_ctrl;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [SYM_W-1:0]      div_rem;

  rcca_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (val_q),
    .divisor_i  (base_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_count_q <= SYMBOL_COUNT_RESET;
      banned_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SYMBOL_COUNT: sym_count_q <= cfg_data_i[5:0];
        CFG_BANNED_MASK:  banned_q    <= cfg_data_i;
        default:          sym_count_q <= sym_count_q;
      endcase
    end
  end

  // Saturate the candidate count.
  assign cnt_eff = (sym_count_q > 6'(MAX_SYMBOLS)) ? SYM_W'(MAX_SYMBOLS)
                                                   : SYM_W'(sym_count_q);
  assign cur_allowed = !banned_q[idx_q];

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    base_d      = base_q;
    idx_d       = idx_q;
    seen_d      = seen_q;
    ndig_d      = ndig_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q;
    sym_d       = sym_q;
    last_d      = last_q;
    empty_d     = empty_q;
    bad_d       = bad_q;
    mem_we      = 1'b0;
    div_ctrl    = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          val_d   = value_i;
          base_d  = '0;
          idx_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q < cnt_eff) begin
          if (cur_allowed) begin
            base_d = base_q + 1'b1;
          end
          idx_d = idx_q + 1'b1;
        end else if (base_q < SYM_W'(2)) begin
          sym_d       = '0;
          last_d      = 1'b1;
          empty_d     = 1'b0;
          bad_d       = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_EMIT;
        end else if (val_q == '0) begin
          sym_d       = '0;
          last_d      = 1'b1;
          empty_d     = 1'b1;
          bad_d       = 1'b0;
          out_valid_d = 1'b1;
          state_d     = ST_EMIT;
        end else begin
          ndig_d  = '0;
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_ctrl.start = 1'b1;
        state_d        = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          mem_we = 1'b1;
          val_d  = div_quot;
          ndig_d = ndig_q + 1'b1;
          if (div_quot == '0) begin
            rd_idx_d = ndig_q[DIG_AW-1:0];
            state_d  = ST_FETCH;
          end else begin
            state_d = ST_DIV_GO;
          end
        end
      end
      ST_FETCH: begin
        // dig_rd_q picks up the stored digit at the end of this cycle
        idx_d   = '0;
        seen_d  = '0;
        state_d = ST_MAP;
      end
      ST_MAP: begin
        if (cur_allowed && seen_q == dig_rd_q) begin
          sym_d       = glyph_of(idx_q);
          last_d      = (rd_idx_q == '0);
          empty_d     = 1'b0;
          bad_d       = 1'b0;
          out_valid_d = 1'b1;
          state_d     = ST_EMIT;
        end else begin
          if (cur_allowed) begin
            seen_d = seen_q + 1'b1;
          end
          idx_d = idx_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            rd_idx_d = rd_idx_q - 1'b1;
            state_d  = ST_FETCH;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    base_q   <= base_d;
    idx_q    <= idx_d;
    seen_q   <= seen_d;
    ndig_q   <= ndig_d;
    rd_idx_q <= rd_idx_d;
    sym_q    <= sym_d;
    last_q   <= last_d;
    empty_q  <= empty_d;
    bad_q    <= bad_d;
  end

  // Digit store: written least significant first, read back in reverse.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dig_mem[ndig_q[DIG_AW-1:0]] <= div_rem;
    end
    dig_rd_q <= dig_mem[rd_idx_q];
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign symbol_char_o = sym_q;
  assign is_last_o     = last_q;
  assign is_empty_o    = empty_q;
  assign bad_base_o    = bad_q;

endmodule

### bench/rcca_digit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcca_digit_checker
// Follows the alphabet register writes and spells every accepted value in the
// restricted radix. Each output transaction is then compared field by field
// with the oldest spelled symbol.
// ----------------------------------------------------------------------------
module rcca_digit_checker
  import rcca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [CHAR_W-1:0]     symbol_char_i,
  input  logic                  is_last_i,
  input  logic                  is_empty_i,
  input  logic                  bad_base_i,
  output int                    outstanding_o,
  output int                    mismatches_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] symbol_char;
    logic              is_last;
    logic              is_empty;
    logic              bad_base;
  } symbol_rec_t;

  logic [5:0]       symbol_count_q;
  logic [CFG_W-1:0] banned_mask_q;
  symbol_rec_t      spelled_q[$];
  symbol_rec_t      want;
  int               n_pending = 0;
  int               n_bad = 0;

  assign outstanding_o = n_pending;
  assign mismatches_o  = n_bad;

  // Spell one value with the current alphabet, most significant digit first.
  function automatic void spell_value(input logic [VALUE_BITS-1:0] v);
    int          alphabet[MAX_SYMBOLS];
    int          digit_buf[64];
    int          n_cand;
    int          radix;
    int          ndig;
    int          sym;
    int          i;
    logic [63:0] rest;
    symbol_rec_t rec;
    n_cand = (symbol_count_q > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(symbol_count_q);
    radix  = 0;
    ndig   = 0;
    rest   = 64'(v);
    for (i = 0; i < n_cand; i++) begin
      if (!banned_mask_q[i]) begin
        alphabet[radix] = i;
        radix++;
      end
    end
    rec = '0;
    if (radix < 2) begin
      // too few symbols wins over a zero value
      rec.is_last  = 1'b1;
      rec.bad_base = 1'b1;
      spelled_q.push_back(rec);
    end else if (rest == 64'd0) begin
      rec.is_last  = 1'b1;
      rec.is_empty = 1'b1;
      spelled_q.push_back(rec);
    end else begin
      while (rest != 64'd0) begin
        digit_buf[ndig] = int'(rest % 64'(radix));
        rest = rest / 64'(radix);
        ndig++;
      end
      for (i = ndig - 1; i >= 0; i--) begin
        sym = alphabet[digit_buf[i]];
        if (sym < int'(DEC_DIGITS)) begin
          rec.symbol_char = ASCII_ZERO + CHAR_W'(sym);
        end else begin
          rec.symbol_char = ASCII_UPPER_A + CHAR_W'(sym - int'(DEC_DIGITS));
        end
        rec.is_last = (i == 0);
        spelled_q.push_back(rec);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbol_count_q = SYMBOL_COUNT_RESET;
      banned_mask_q  = '0;
      spelled_q.delete();
      n_pending = 0;
      n_bad     = 0;
    end else begin
      // retire results before taking the next value
      if (out_valid_i && out_ready_i) begin
        if (spelled_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("%0t: unexpected result char %0d last %0b empty %0b bad_base %0b",
                     $realtime, symbol_char_i, is_last_i, is_empty_i, bad_base_i);
          end
        end else begin
          want = spelled_q.pop_front();
          if (symbol_char_i !== want.symbol_char || is_last_i !== want.is_last ||
              is_empty_i !== want.is_empty || bad_base_i !== want.bad_base) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("%0t: mismatch, expected char %0d last %0b empty %0b bad_base %0b",
                       $realtime, want.symbol_char, want.is_last, want.is_empty,
                       want.bad_base);
              $display("%0t:           got      char %0d last %0b empty %0b bad_base %0b",
                       $realtime, symbol_char_i, is_last_i, is_empty_i, bad_base_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        spell_value(value_i);
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SYMBOL_COUNT: symbol_count_q = cfg_data_i[5:0];
          CFG_BANNED_MASK:  banned_mask_q  = cfg_data_i;
          default: ;
        endcase
      end
      n_pending = spelled_q.size();
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives values and alphabet settings into the restricted-radix converter,
// with random stalls on both channels, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module testbench;
  import rcca_pkg::*;

  localparam int IDLE_LIMIT    = 30000;
  localparam int SETTLE_CYCLES = 100;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_W-1:0]      cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] in_value;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CHAR_W-1:0]     symbol_char;
  logic                  is_last;
  logic                  is_empty;
  logic                  bad_base;
  logic                  calm_tail = 1'b0;
  int                    out_hold = 0;
  int                    idle_cycles = 0;
  int                    outstanding;
  int                    mismatches;

  always #10 clk_i = ~clk_i;

  radix_convert_custom_alphabet_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .value_i      (in_value),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .symbol_char_o(symbol_char),
    .is_last_o    (is_last),
    .is_empty_o   (is_empty),
    .bad_base_o   (bad_base)
  );

  rcca_digit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .value_i      (in_value),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .symbol_char_i(symbol_char),
    .is_last_i    (is_last),
    .is_empty_i   (is_empty),
    .bad_base_i   (bad_base),
    .outstanding_o(outstanding),
    .mismatches_o (mismatches)
  );

  // Hold the output channel off in bursts of random length, none in the calm tail.
  always @(negedge clk_i) begin
    if (out_hold > 0) begin
      out_hold  <= out_hold - 1;
      out_ready <= 1'b0;
    end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
      out_hold  <= $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Wait until every spelled symbol has come out, then let the core go quiet.
  task automatic settle(input int extra);
    while (outstanding != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic set_alphabet(input logic [5:0] count, input logic [CFG_W-1:0] mask);
    settle(8);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SYMBOL_COUNT;
    cfg_data <= CFG_W'(count);
    @(negedge clk_i);
    cfg_idx  <= CFG_BANNED_MASK;
    cfg_data <= mask;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic push_value(input logic [VALUE_BITS-1:0] v);
    int gap;
    gap = (!calm_tail && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
    repeat (gap + 1) @(negedge clk_i);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [63:0]      raw;
    logic [5:0]       count;
    logic [CFG_W-1:0] mask;
    int               phase;
    int               k;
    rst_ni   = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_SYMBOL_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    in_value = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // decimal alphabet out of reset
    push_value('0);
    push_value(63'd1);
    push_value(63'd9);
    push_value(63'd10);
    push_value('1);

    // binary: the widest value gives the longest digit string
    set_alphabet(6'd2, '0);
    push_value('1);
    push_value('0);
    push_value(63'd1);

    // oversized count saturates to the full alphabet
    set_alphabet(6'h3F, '0);
    push_value('1);
    push_value(63'd35);
    push_value(63'd36);

    // everything banned: bad base, even for zero
    set_alphabet(6'd36, '1);
    push_value('0);
    push_value(63'd5);

    set_alphabet(6'd0, '0);
    push_value(63'd7);
    set_alphabet(6'd1, '0);
    push_value(63'd3);

    // symbol 0 banned, bans above the count ignored: digit 0 shows as '1'
    set_alphabet(6'd12, 36'hF_FFFF_F001);
    push_value('0);
    push_value(63'd11);
    push_value(63'd120);
    push_value('1);

    // a single survivor is still a bad base
    set_alphabet(6'd5, 36'h0_0000_001E);
    push_value(63'd4);

    set_alphabet(6'd36, 36'h5_5555_5555);
    push_value(VALUE_BITS'({32{2'b10}}));
    push_value('1);

    for (phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 7))
        0:       count = 6'($urandom_range(0, 63));
        default: count = 6'($urandom_range(2, MAX_SYMBOLS));
      endcase
      case ($urandom_range(0, 5))
        0:       mask = '0;
        1:       mask = CFG_W'({$urandom, $urandom});
        default: mask = CFG_W'({$urandom, $urandom}) & CFG_W'({$urandom, $urandom}) &
                        CFG_W'({$urandom, $urandom});
      endcase
      set_alphabet(count, mask);
      // no stalls in the last stretch of the run
      calm_tail = (phase >= 10);
      for (k = 0; k < 10; k++) begin
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 19))
          0:       push_value('0);
          1:       push_value('1);
          default: push_value(raw[VALUE_BITS-1:0] >> $urandom_range(0, VALUE_BITS - 1));
        endcase
      end
    end

    settle(SETTLE_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
src/rcca_pkg.sv
src/rcca_divider.sv
src/radix_convert_custom_alphabet_core.sv
bench/rcca_digit_checker.sv
bench/testbench.sv
